@@ rtl/signed_int_to_decimal_ascii_core_macros.svh @@
// assertion macros used by the checker file of the decimal text core
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SIDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SIDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/sida_pkg.sv @@
// types, constants and helper functions of the decimal text core
`default_nettype none

package sida_pkg;

    // field widths
    localparam int VALUE_W = 32;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 31;
    localparam int CHAR_W  = 8;

    // magnitude and digit position widths
    localparam int MAG_W    = 32;
    localparam int POS_W    = 4;
    localparam int SCALED_W = 34;
    localparam int DIGIT_W  = 4;
    localparam int TOTAL_W  = 4;

    // a 32-bit magnitude has at most ten decimal digits
    localparam int MAG_DIGITS = 10;

    // digit buffer limit; digits above it are dropped and only the low digits are printed
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_LIMIT = (MAX_DIGITS > MAG_DIGITS) ? MAG_DIGITS : MAX_DIGITS;

    // depth of the queue between front and back
    localparam int JOB_QUEUE_DEPTH = 2;

    // character codes
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CHAN_W-1:0]         channel;
        logic [COUNT_W-1:0]        count_in;
    } sida_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic [CHAN_W-1:0]  out_channel;
        logic               last;
        logic [COUNT_W-1:0] count_out;
    } sida_result_t;

    // classified item handed from front to back
    typedef struct packed {
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [POS_W-1:0]   top_pos;
        logic [CHAN_W-1:0]  channel;
        logic [COUNT_W-1:0] count;
    } sida_job_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_SIGN,
        BACK_DIGIT
    } sida_back_state_t;

    // ten to the power of a digit position
    function automatic logic [SCALED_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [SCALED_W-1:0] p;
        unique case (pos)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sida_front.sv @@
// front part: registers an item, takes its magnitude and sizes its text
`default_nettype none

module sida_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    output logic                 full,
    input  sida_pkg::sida_item_t item,
    output logic                 job_valid,
    input  wire                  job_ready,
    output sida_pkg::sida_job_t  job
);
    import sida_pkg::*;

    logic               stage_valid_reg, stage_valid_next;
    logic               stage_neg_reg;
    logic [MAG_W-1:0]   stage_mag_reg;
    logic [CHAN_W-1:0]  stage_chan_reg;
    logic [COUNT_W-1:0] stage_count_reg;

    logic               load;
    logic [POS_W-1:0]   top_pos;
    logic [POS_W-1:0]   shown_digits;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W:0]   count_sum;

    // stage handshake
    assign full      = stage_valid_reg && !job_ready;
    assign load      = push && !full;
    assign job_valid = stage_valid_reg;

    always_comb
    begin
        stage_valid_next = load || (stage_valid_reg && !job_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // sign and magnitude capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_neg_reg   <= item.value[VALUE_W-1];
            stage_mag_reg   <= item.value[VALUE_W-1] ? MAG_W'(-item.value)
                                                     : MAG_W'(item.value);
            stage_chan_reg  <= item.channel;
            stage_count_reg <= item.count_in;
        end
    end

    // highest nonzero digit position, parallel compares against powers of ten
    always_comb
    begin
        top_pos = '0;
        for (int k = 1; k < MAG_DIGITS; k++)
        begin
            if ({{(SCALED_W-MAG_W){1'b0}}, stage_mag_reg} >= pow10(POS_W'(k)))
            begin
                top_pos = top_pos + POS_W'(1);
            end
        end
    end

    // characters of this value and the saturating running count
    always_comb
    begin
        if (top_pos >= POS_W'(DIGIT_LIMIT))
        begin
            shown_digits = POS_W'(DIGIT_LIMIT);
        end
        else
        begin
            shown_digits = top_pos + POS_W'(1);
        end
        total     = TOTAL_W'(shown_digits) + TOTAL_W'(stage_neg_reg);
        count_sum = {1'b0, stage_count_reg} + (COUNT_W+1)'(total);
    end

    always_comb
    begin
        job.neg     = stage_neg_reg;
        job.mag     = stage_mag_reg;
        job.top_pos = top_pos;
        job.channel = stage_chan_reg;
        job.count   = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
    end

endmodule

`default_nettype wire

@@ rtl/sida_queue.sv @@
// short queue of classified items between front and back
`default_nettype none

module sida_queue #(
    parameter int DEPTH = sida_pkg::JOB_QUEUE_DEPTH
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 wr_valid,
    output logic                wr_ready,
    input  sida_pkg::sida_job_t wr_data,
    output logic                rd_valid,
    input  wire                 rd_take,
    output sida_pkg::sida_job_t rd_data
);
    import sida_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    sida_job_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic do_wr;
    logic do_rd;

    // status
    assign wr_ready = (fill_reg != FILL_MAX);
    assign rd_valid = (fill_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;
    assign rd_data  = entry_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sida_back.sv @@
// back part: emits the sign and one decimal digit per cycle while its output slot is free, top digit first
`default_nettype none

module sida_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   job_valid,
    output logic                  job_take,
    input  sida_pkg::sida_job_t   job,
    output logic                  empty,
    input  wire                   pop,
    output sida_pkg::sida_result_t result
);
    import sida_pkg::*;

    sida_back_state_t   state_reg, state_next;
    logic [MAG_W-1:0]   residue_reg, residue_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CHAN_W-1:0]  chan_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg, out_valid_next;
    sida_result_t       out_data_reg;

    logic [SCALED_W-1:0] scale;
    logic [SCALED_W-1:0] multiple [MAG_DIGITS];
    logic [DIGIT_W-1:0]  digit;
    logic [MAG_W-1:0]    remainder;
    logic                shown_pos;
    logic                slot_free;
    logic                step;
    logic                emit;
    logic                finishing;
    sida_result_t        emit_data;

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

    // digit at the current position by parallel compares on its multiples
    always_comb
    begin
        scale = pow10(pos_reg);
        for (int k = 0; k < MAG_DIGITS; k++)
        begin
            multiple[k] = scale * SCALED_W'(k);
        end
        digit = '0;
        for (int k = 1; k < MAG_DIGITS; k++)
        begin
            if ({{(SCALED_W-MAG_W){1'b0}}, residue_reg} >= multiple[k])
            begin
                digit = digit + DIGIT_W'(1);
            end
        end
        remainder = residue_reg - multiple[digit][MAG_W-1:0];
    end

    // positions above the digit limit are stepped over silently
    assign shown_pos = (pos_reg < POS_W'(DIGIT_LIMIT));
    assign slot_free = !out_valid_reg || pop;

    // sequencer outputs
    always_comb
    begin
        step      = 1'b0;
        emit      = 1'b0;
        emit_data = '0;
        emit_data.out_channel = chan_reg;
        emit_data.count_out   = count_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                step = 1'b0;
            end
            BACK_SIGN:
            begin
                step = slot_free;
                emit = slot_free;
                emit_data.character = CHAR_MINUS;
                emit_data.last      = 1'b0;
            end
            BACK_DIGIT:
            begin
                step = slot_free || !shown_pos;
                emit = slot_free && shown_pos;
                emit_data.character = CHAR_ZERO + CHAR_W'(digit);
                emit_data.last      = (pos_reg == '0);
            end
            default:
            begin
                step = 1'b0;
            end
        endcase
        finishing = (state_reg == BACK_DIGIT) && step && (pos_reg == '0);
        job_take  = job_valid && ((state_reg == BACK_IDLE) || finishing);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (job_take)
                begin
                    state_next = job.neg ? BACK_SIGN : BACK_DIGIT;
                end
            end
            BACK_SIGN:
            begin
                if (step)
                begin
                    state_next = BACK_DIGIT;
                end
            end
            BACK_DIGIT:
            begin
                if (job_take)
                begin
                    state_next = job.neg ? BACK_SIGN : BACK_DIGIT;
                end
                else if (finishing)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // working value and position
    always_comb
    begin
        residue_next = residue_reg;
        pos_next     = pos_reg;
        if (job_take)
        begin
            residue_next = job.mag;
            pos_next     = job.top_pos;
        end
        else if ((state_reg == BACK_DIGIT) && step)
        begin
            residue_next = remainder;
            pos_next     = pos_reg - POS_W'(1);
        end
        out_valid_next = emit || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        residue_reg <= residue_next;
        pos_reg     <= pos_next;
        if (job_take)
        begin
            chan_reg  <= job.channel;
            count_reg <= job.count;
        end
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Signed integer to decimal ASCII text, top level.
//
// Input channel: an item {value, channel, count_in} is taken at a rising edge
// with push high and full low. Result channel: while empty is low the oldest
// character is on result; it is taken at an edge with pop high.
// Each value gives one character per transaction, top digit first, with
// a leading '-' for negative values; last marks the final digit and
// count_out (count_in plus characters, saturating) is the same on all.
// The first character of an item passes the front stage register, a queue
// entry, the back part's working registers and its output register.
// Throughput: the back part emits one character per cycle while the
// receiver takes them, so an item occupies it for its 1 to 11 characters;
// digit positions above the digit limit are stepped over without a result.
// The front stage and a two-entry queue keep taking items meanwhile.
// Reset clears all control state; no clearing pass follows it.
// A stalled receiver holds the shown character; the back part stops,
// then the queue fills and full rises.
`default_nettype none

module signed_int_to_decimal_ascii_core #(
    parameter int QUEUE_DEPTH = sida_pkg::JOB_QUEUE_DEPTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    output logic                   full,
    input  sida_pkg::sida_item_t   item,
    output logic                   empty,
    input  wire                    pop,
    output sida_pkg::sida_result_t result
);
    import sida_pkg::*;

    logic      front_valid;
    logic      front_ready;
    sida_job_t front_job;
    logic      queue_valid;
    logic      queue_take;
    sida_job_t queue_job;

    // classify items
    sida_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // decouple front and back
    sida_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_job),
        .rd_valid (queue_valid),
        .rd_take  (queue_take),
        .rd_data  (queue_job)
    );

    // emit characters
    sida_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_valid),
        .job_take  (queue_take),
        .job       (queue_job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ rtl/sida_checker.sv @@
// port-level checks of the decimal text core and their binding
`default_nettype none

`include "signed_int_to_decimal_ascii_core_macros.svh"

module sida_checker (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    push,
    input wire                    full,
    input sida_pkg::sida_item_t   item,
    input wire                    empty,
    input wire                    pop,
    input sida_pkg::sida_result_t result
);
    import sida_pkg::*;

    logic unused_in;
    assign unused_in = push ^ full ^ (^item);

    // a waiting transaction is held until taken
    `SIDA_ASSERT_NXT(a_result_held, clk, rst_n, !empty && !pop, !empty && $stable(result))

    // only the minus sign or a decimal digit is shown
    `SIDA_ASSERT_IMP(a_char_legal, clk, rst_n, !empty, (result.character == CHAR_MINUS) || ((result.character >= CHAR_ZERO) && (result.character <= CHAR_ZERO + 8'd9)))

    // the sign never ends a value's text
    `SIDA_ASSERT_IMP(a_sign_not_last, clk, rst_n, !empty && (result.character == CHAR_MINUS), !result.last)

    // every value prints at least one character, so the count is never zero
    `SIDA_ASSERT_IMP(a_count_nonzero, clk, rst_n, !empty, result.count_out != '0)

endmodule

bind signed_int_to_decimal_ascii_core sida_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench for the signed integer to decimal text core
`timescale 1ns / 100ps

module testbench;
    import sida_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 150;

    // expected decimal text of every accepted value, in arrival order
    class text_scoreboard;
        sida_result_t expected_chars[$];
        int unsigned  errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $time);
            errors++;
        endtask

        // build the characters of one accepted value
        function void note_item(sida_item_t it);
            logic [32:0]  mag;
            logic [3:0]   digits[$];
            logic         neg;
            logic [31:0]  new_count;
            int           n_chars;
            sida_result_t r;
            neg = it.value[31];
            mag = neg ? (33'h1_0000_0000 - {1'b0, it.value}) : {1'b0, it.value};
            // digits come out low first; keep them high first
            do
            begin
                digits.push_front(4'(mag % 10));
                mag = mag / 10;
            end while (mag != 0 && digits.size() < MAX_DIGITS);
            n_chars   = digits.size() + (neg ? 1 : 0);
            new_count = {1'b0, it.count_in} + 32'(n_chars);
            if (new_count > {1'b0, COUNT_MAX})
                new_count = {1'b0, COUNT_MAX};
            r.out_channel = it.channel;
            r.count_out   = new_count[COUNT_W-1:0];
            if (neg)
            begin
                r.character = CHAR_MINUS;
                r.last      = 1'b0;
                expected_chars.push_back(r);
            end
            foreach (digits[i])
            begin
                r.character = CHAR_ZERO + {4'd0, digits[i]};
                r.last      = (i == digits.size() - 1);
                expected_chars.push_back(r);
            end
        endfunction

        // compare one accepted character with the oldest expectation
        task check_result(sida_result_t got);
            sida_result_t want;
            if (expected_chars.size() == 0)
            begin
                report("unexpected character", 0, got.character);
                return;
            end
            want = expected_chars.pop_front();
            if (got.character !== want.character)
                report("character", want.character, got.character);
            if (got.out_channel !== want.out_channel)
                report("out_channel", want.out_channel, got.out_channel);
            if (got.last !== want.last)
                report("last", want.last, got.last);
            if (got.count_out !== want.count_out)
                report("count_out", want.count_out, got.count_out);
        endtask
    endclass

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         push  = 1'b0;
    logic         pop   = 1'b0;
    sida_item_t   item  = '0;
    logic         full;
    logic         empty;
    sida_result_t result;

    text_scoreboard sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    logic        hold_go     = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned cycles      = 0;

    signed_int_to_decimal_ascii_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // clock
    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL signed_int_to_decimal_ascii_core");
            $finish;
        end
    end

    // receiver: check accepted transactions, then choose the next pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic sida_item_t make_item(logic [31:0] v, logic [7:0] ch, logic [30:0] cnt);
        sida_item_t it;
        it.value    = v;
        it.channel  = ch;
        it.count_in = cnt;
        return it;
    endfunction

    // random value with a spread of digit counts, signs and counts
    function automatic sida_item_t random_item();
        longint unsigned span;
        longint unsigned mag;
        logic [31:0]     v;
        logic [30:0]     cnt;
        int unsigned     kind;
        int              n;
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            n    = $urandom_range(1, 10);
            span = 1;
            for (int i = 0; i < n; i++)
                span = span * 10;
            mag = longint'($urandom) % span;
            v   = mag[31:0];
            if ($urandom_range(1))
                v = -v;
        end
        else if (kind < 8)
            v = $urandom;
        else if (kind == 8)
        begin
            case ($urandom_range(4))
                0: v = 32'h0000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h8000_0000;
                3: v = 32'hffff_ffff;
                default: v = 32'h0000_0001;
            endcase
        end
        else
            v = 32'($urandom_range(40)) - 32'd20;
        if ($urandom_range(3) == 0)
            cnt = COUNT_MAX - 31'($urandom_range(12));
        else
            cnt = 31'($urandom >> 1);
        return make_item(v, 8'($urandom_range(255)), cnt);
    endfunction

    // offer one item until the block takes it; push stays high afterwards
    task send_item(sida_item_t it);
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        sb.note_item(it);
    endtask

    // random gaps on the input side
    task sender_gap();
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    task send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            sender_gap();
            send_item(random_item());
        end
    endtask

    // input quiet until every expected character has come
    task wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // stimulus and end of run
    initial
    begin
        sida_item_t directed[$];
        directed.push_back(make_item(32'd0, 8'd0, 31'd0));
        directed.push_back(make_item(32'd1, 8'd255, 31'd0));
        directed.push_back(make_item(-32'd1, 8'd17, 31'd5));
        directed.push_back(make_item(32'd9, 8'd1, 31'd100));
        directed.push_back(make_item(32'd10, 8'd128, 31'd7));
        directed.push_back(make_item(-32'd10, 8'd200, 31'd0));
        directed.push_back(make_item(32'h7fff_ffff, 8'd255, 31'd0));
        directed.push_back(make_item(32'h8000_0000, 8'd0, 31'd0));
        directed.push_back(make_item(32'd1000000000, 8'd3, 31'd12));
        directed.push_back(make_item(32'd999999999, 8'd4, 31'd99));
        directed.push_back(make_item(-32'd999999999, 8'd5, 31'd1));
        directed.push_back(make_item(32'd123456789, 8'd170, 31'd0));
        directed.push_back(make_item(-32'd2147483647, 8'd85, 31'd3));
        // count saturation and the boundary just below it
        directed.push_back(make_item(32'd0, 8'd9, COUNT_MAX));
        directed.push_back(make_item(32'h8000_0000, 8'd10, COUNT_MAX - 31'd11));
        directed.push_back(make_item(32'h8000_0000, 8'd11, COUNT_MAX - 31'd10));
        directed.push_back(make_item(32'h7fff_ffff, 8'd12, COUNT_MAX - 31'd9));
        directed.push_back(make_item(-32'd5, 8'd13, COUNT_MAX));
        directed.push_back(make_item(-32'd42, 8'd255, COUNT_MAX - 31'd2));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender busy, receiver often idle
        tx_idle_pct = 18;
        rx_idle_pct = 83;
        foreach (directed[i])
            send_item(directed[i]);
        send_random(PHASE_ITEMS);
        wait_drained();

        // roles swapped
        tx_idle_pct = 83;
        rx_idle_pct = 18;
        send_random(PHASE_ITEMS);

        // no idling; long receiver stall fills the block
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = ~hold_go;
        send_random(40);
        send_random(PHASE_ITEMS - 40);
        push <= 1'b0;

        // drain and let late characters show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS signed_int_to_decimal_ascii_core");
        else
            $display("FAIL signed_int_to_decimal_ascii_core");
        $finish;
    end

endmodule
